/* sv/hrlp_pkg.sv */
package hrlp_pkg;

  typedef enum logic [4:0] {
    ST_START       = 5'd0,
    ST_METHOD      = 5'd1,
    ST_SP_URI      = 5'd2,
    ST_AFTER_SLASH = 5'd3,
    ST_CHECK_URI   = 5'd4,
    ST_URI         = 5'd5,
    ST_H09         = 5'd6,
    ST_H           = 5'd7,
    ST_HT          = 5'd8,
    ST_HTT         = 5'd9,
    ST_HTTP        = 5'd10,
    ST_MAJ1        = 5'd11,
    ST_MAJ         = 5'd12,
    ST_MIN1        = 5'd13,
    ST_MIN         = 5'd14,
    ST_SP_END      = 5'd15,
    ST_ALMOST      = 5'd16
  } state_e;

  typedef enum logic [2:0] {
    EV_CONT    = 3'd0,
    EV_METHOD  = 3'd1,
    EV_URI     = 3'd2,
    EV_VERSION = 3'd3,
    EV_LINE    = 3'd4,
    EV_ERROR   = 3'd5
  } event_e;

  typedef enum logic [2:0] {
    ER_NONE    = 3'd0,
    ER_METHOD  = 3'd1,
    ER_REQUEST = 3'd2,
    ER_UNSUP   = 3'd3,
    ER_VERSION = 3'd4,
    ER_ENDING  = 3'd5,
    ER_LONG    = 3'd6
  } err_e;

  localparam logic [7:0] BCr    = 8'h0d;
  localparam logic [7:0] BLf    = 8'h0a;
  localparam logic [7:0] BSpace = 8'h20;
  localparam logic [7:0] BDel   = 8'h7f;

  localparam logic [15:0] MaxLineReset = 16'd8192;
  localparam logic [13:0] MinorMax     = 14'd999;

  localparam logic [255:0] UsualTab = {
    32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
    32'h7fffffff, 32'hffffffff, 32'h7fff37d6, 32'h00000000
  };

  function automatic logic is_plain_uri(input logic [7:0] c);
    return UsualTab[c];
  endfunction

  function automatic logic is_method_char(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || c == "_" || c == "-";
  endfunction

  function automatic logic is_ctl(input logic [7:0] c);
    return c < BSpace || c == BDel;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

endpackage

/* sv/http_request_line_parser.sv */
// HTTP request line parser: one byte enters per transaction and one result leaves for each,
// in order. A byte is taken in every cycle in which the result register is empty or being
// drained, so the sustained rate is one byte per clock while out_stall_i is low; the result
// appears in the cycle after its byte is taken, from the single result register behind the
// parser state logic. The line byte limit is written on the configuration channel (always
// ready) and must only change while no byte is in flight. Errors stay latched until reset.
module http_request_line_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] max_line_bytes_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  event_res_o,
  output logic [2:0]  error_code_o,
  output logic [7:0]  token_byte_o,
  output logic        token_append_o,
  output logic [3:0]  version_major_o,
  output logic [9:0]  version_minor_o
);
  import hrlp_pkg::*;

  logic [15:0] max_line_q;
  state_e      st_q, st_d;
  logic        err_latched_q;
  err_e        err_code_q;
  logic [3:0]  major_q, major_d;
  logic [9:0]  minor_q, minor_d;
  logic [15:0] cnt_q, cnt_d;

  event_e      ev;
  err_e        code;
  logic        app;
  logic [7:0]  c;
  logic [13:0] minor_next;
  logic        in_acc;

  logic        out_valid_q;
  event_e      ev_q;
  err_e        code_q;
  logic [7:0]  byte_q;
  logic        app_q;
  logic [3:0]  ver_major_q;
  logic [9:0]  ver_minor_q;

  assign c          = in_byte_i;
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign minor_next = ({4'b0, minor_q} << 3) + ({4'b0, minor_q} << 1)
                    + {10'b0, c[3:0]};

  always_comb begin
    st_d    = st_q;
    major_d = major_q;
    minor_d = minor_q;
    cnt_d   = cnt_q;
    ev      = EV_CONT;
    code    = ER_NONE;
    app     = 1'b0;
    priority if (err_latched_q) begin
      ev   = EV_ERROR;
      code = err_code_q;
    end else if ({1'b0, cnt_q} + 17'd1 > {1'b0, max_line_q}) begin
      ev   = EV_ERROR;
      code = ER_LONG;
    end else begin
      cnt_d = cnt_q + 16'd1;
      unique case (st_q)
        ST_METHOD: begin
          if (c == BSpace) begin
            st_d = ST_SP_URI;
            ev   = EV_METHOD;
          end else if (!is_method_char(c)) begin
            ev   = EV_ERROR;
            code = ER_METHOD;
          end else begin
            app = 1'b1;
          end
        end
        ST_SP_URI: begin
          if (c == "/") begin
            app  = 1'b1;
            st_d = ST_AFTER_SLASH;
          end else if (c != BSpace) begin
            ev   = EV_ERROR;
            code = ER_REQUEST;
          end
        end
        ST_AFTER_SLASH, ST_CHECK_URI, ST_URI: begin
          priority if (is_plain_uri(c)) begin
            app = 1'b1;
            if (st_q == ST_AFTER_SLASH) st_d = ST_CHECK_URI;
          end else if (c == BSpace) begin
            st_d = ST_H09;
            ev   = EV_URI;
          end else if (c == BCr) begin
            major_d = 4'd0;
            minor_d = 10'd9;
            st_d    = ST_ALMOST;
          end else if (c == BLf) begin
            major_d = 4'd0;
            minor_d = 10'd9;
            ev      = EV_LINE;
          end else if (st_q == ST_AFTER_SLASH &&
                       (c == "." || c == "%" || c == "/" || c == "?" || c == "#")) begin
            app  = 1'b1;
            st_d = ST_URI;
          end else if (st_q == ST_AFTER_SLASH && c == "+") begin
            app = 1'b1;
          end else if (st_q == ST_CHECK_URI && c == "/") begin
            app  = 1'b1;
            st_d = ST_AFTER_SLASH;
          end else if (st_q == ST_CHECK_URI && (c == "%" || c == "?" || c == "#")) begin
            app  = 1'b1;
            st_d = ST_URI;
          end else if (is_ctl(c)) begin
            ev   = EV_ERROR;
            code = ER_REQUEST;
          end else begin
            app = 1'b1;
            if (st_q == ST_AFTER_SLASH) st_d = ST_CHECK_URI;
          end
        end
        ST_H09: begin
          priority if (c == BSpace) begin
          end else if (c == "H") begin
            st_d = ST_H;
          end else if (c == BCr) begin
            major_d = 4'd0;
            minor_d = 10'd9;
            st_d    = ST_ALMOST;
          end else if (c == BLf) begin
            major_d = 4'd0;
            minor_d = 10'd9;
            ev      = EV_LINE;
          end else begin
            ev   = EV_ERROR;
            code = ER_REQUEST;
          end
        end
        ST_H, ST_HT: begin
          if (c != "T") begin
            ev   = EV_ERROR;
            code = ER_REQUEST;
          end else begin
            st_d = (st_q == ST_H) ? ST_HT : ST_HTT;
          end
        end
        ST_HTT: begin
          if (c != "P") begin
            ev   = EV_ERROR;
            code = ER_REQUEST;
          end else begin
            st_d = ST_HTTP;
          end
        end
        ST_HTTP: begin
          if (c != "/") begin
            ev   = EV_ERROR;
            code = ER_REQUEST;
          end else begin
            st_d = ST_MAJ1;
          end
        end
        ST_MAJ1: begin
          priority if (c < "1" || c > "9") begin
            ev   = EV_ERROR;
            code = ER_REQUEST;
          end else if (c != "1") begin
            ev   = EV_ERROR;
            code = ER_UNSUP;
          end else begin
            major_d = 4'd1;
            st_d    = ST_MAJ;
          end
        end
        ST_MAJ: begin
          priority if (c == ".") begin
            st_d = ST_MIN1;
          end else if (!is_digit(c)) begin
            ev   = EV_ERROR;
            code = ER_REQUEST;
          end else begin
            ev   = EV_ERROR;
            code = ER_UNSUP;
          end
        end
        ST_MIN1: begin
          if (!is_digit(c)) begin
            ev   = EV_ERROR;
            code = ER_VERSION;
          end else begin
            minor_d = {6'b0, c[3:0]};
            st_d    = ST_MIN;
          end
        end
        ST_MIN: begin
          priority if (c == BCr) begin
            st_d = ST_ALMOST;
            ev   = EV_VERSION;
          end else if (c == BLf) begin
            ev = EV_LINE;
          end else if (c == BSpace) begin
            st_d = ST_SP_END;
            ev   = EV_VERSION;
          end else if (!is_digit(c) || minor_next > MinorMax) begin
            ev   = EV_ERROR;
            code = ER_REQUEST;
          end else begin
            minor_d = minor_next[9:0];
          end
        end
        ST_SP_END: begin
          priority if (c == BSpace) begin
          end else if (c == BCr) begin
            st_d = ST_ALMOST;
          end else if (c == BLf) begin
            ev = EV_LINE;
          end else begin
            ev   = EV_ERROR;
            code = ER_REQUEST;
          end
        end
        ST_ALMOST: begin
          if (c != BLf) begin
            ev   = EV_ERROR;
            code = ER_ENDING;
          end else begin
            ev = EV_LINE;
          end
        end
        default: begin
          priority if (c == BCr || c == BLf) begin
          end else if (!is_method_char(c)) begin
            ev   = EV_ERROR;
            code = ER_METHOD;
          end else begin
            app  = 1'b1;
            st_d = ST_METHOD;
          end
        end
      endcase
    end
    if (ev == EV_ERROR) app = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_line_q <= MaxLineReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_line_q <= max_line_bytes_i;
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q          <= ST_START;
      err_latched_q <= 1'b0;
      err_code_q    <= ER_NONE;
      major_q       <= 4'd0;
      minor_q       <= 10'd0;
      cnt_q         <= 16'd0;
    end else if (in_acc) begin
      if (ev == EV_ERROR) begin
        err_latched_q <= 1'b1;
        err_code_q    <= code;
      end
      if (ev == EV_LINE) begin
        st_q    <= ST_START;
        major_q <= 4'd0;
        minor_q <= 10'd0;
        cnt_q   <= 16'd0;
      end else begin
        st_q    <= st_d;
        major_q <= major_d;
        minor_q <= minor_d;
        cnt_q   <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ev_q        <= ev;
      code_q      <= (ev == EV_ERROR) ? code : ER_NONE;
      byte_q      <= c;
      app_q       <= app;
      ver_major_q <= major_d;
      ver_minor_q <= minor_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_res_o     = ev_q;
  assign error_code_o    = code_q;
  assign token_byte_o    = byte_q;
  assign token_append_o  = app_q;
  assign version_major_o = ver_major_q;
  assign version_minor_o = ver_minor_q;

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_latched_q |=> err_latched_q && $stable(err_code_q))
    else $error("latched error changed");

  a_err_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o == EV_ERROR |-> !token_append_o && error_code_o != ER_NONE)
    else $error("error result with token append or no code");

  a_code_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o != EV_ERROR |-> error_code_o == ER_NONE)
    else $error("error code without error event");

  a_line_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && ev == EV_LINE |=> st_q == ST_START && cnt_q == 16'd0 && minor_q == 10'd0)
    else $error("line done did not clear parser");

  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !err_latched_q && ev != EV_ERROR |=> cnt_q <= max_line_q || cnt_q == 16'd0)
    else $error("byte count passed line limit");

endmodule
